### design/nhl_pkg.sv
// Shared types and character constants for the next-hop list parser.
// No dependencies; imported by every module of the block.
package nhl_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic        status;
        logic [9:0]  host_start;
        logic [10:0] host_length;
        logic [15:0] port_number;
        logic [9:0]  transport_start;
        logic [10:0] transport_length;
        logic        end_of_list;
    } out_word_t;

    typedef enum logic [2:0] {
        PH_BEG  = 3'd0,
        PH_HOST = 3'd1,
        PH_V6   = 3'd2,
        PH_SEP  = 3'd3,
        PH_PORT = 3'd4,
        PH_TRSP = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_REC  = 2'd1,
        RES_ERR  = 2'd2
    } res_kind_t;

    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [15:0] PORT_MAX = 16'hFFFF;

endpackage

### design/next_hop_list_parser.sv
// Next-hop list parser, top level.
// Input channel char_*: one word per string byte (char_byte, last_byte).
// Output channel rec_*: one destination record per entry, on its comma or
// on the string's last byte, or an error record on the offending byte.
// Words are accepted when valid is high and stall is low on that channel.
// A record's byte passes the input register, then the parse logic into the
// result register, whose output drives rec_valid.
// Throughput: one byte per cycle while rec_stall does not hold the result
// register; bytes that give no record are consumed at the same rate.
// When rec_stall is high the result register holds its word, the parse
// stage stops, the input register holds one more byte and then char_stall
// goes high until the receiver takes the waiting record.
// After a syntax error, bytes are consumed silently up to the last byte.
// The last byte of a string returns all parse state to its reset value.
// Reset (rst_n low, asynchronous) empties both registers and puts the parser
// at the start of a new string with byte position zero.
// Depends on nhl_pkg, nhl_in_stage, nhl_parse and nhl_out_stage.
module next_hop_list_parser
    import nhl_pkg::*;
#(
    parameter int MAX_STRING_BYTES = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  in_word_t  char_word,
    output logic      rec_valid,
    input  logic      rec_stall,
    output out_word_t rec_word
);

    logic      take;
    logic      held_valid;
    in_word_t  held_word;
    logic      out_ready;
    logic      res_valid;
    out_word_t res_word;

    nhl_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .take       (take),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    nhl_parse #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (held_valid),
        .item       (held_word),
        .out_ready  (out_ready),
        .take       (take),
        .res_valid  (res_valid),
        .res_word   (res_word)
    );

    nhl_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_word  (res_word),
        .out_ready (out_ready),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_word  (rec_word)
    );

endmodule

### design/nhl_in_stage.sv
// Input register of the next-hop list parser: holds one word until the
// parse stage consumes it. Depends on nhl_pkg.
module nhl_in_stage
    import nhl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     char_valid,
    output logic     char_stall,
    input  in_word_t char_word,
    input  logic     take,
    output logic     held_valid,
    output in_word_t held_word
);

    logic     vld_reg;
    logic     vld_next;
    in_word_t word_reg;
    logic     load;

    assign char_stall = vld_reg && !take;
    assign load       = char_valid && !char_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= char_word;
        end
    end

    assign held_valid = vld_reg;
    assign held_word  = word_reg;

endmodule

### design/nhl_parse.sv
// Parser state and per-byte decode of the next-hop list parser.
// Depends on nhl_pkg; driven by nhl_in_stage, feeds nhl_out_stage.
module nhl_parse
    import nhl_pkg::*;
#(
    parameter int MAX_STRING_BYTES = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  in_word_t  item,
    input  logic      out_ready,
    output logic      take,
    output logic      res_valid,
    output out_word_t res_word
);

    localparam int POS_W = $clog2(MAX_STRING_BYTES);
    localparam int SPN_W = POS_W + 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_STRING_BYTES - 1);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SPN_W-1:0] tok_reg, tok_next;
    logic [SPN_W-1:0] hs_reg, hs_next;
    logic [SPN_W-1:0] hl_reg, hl_next;
    logic [15:0]      port_reg, port_next;
    logic [SPN_W-1:0] ts_reg, ts_next;
    logic [SPN_W-1:0] tl_reg, tl_next;
    logic             err_reg, err_next;

    logic [7:0]       c;
    logic             last;
    logic             ws;
    logic             alpha;
    logic [SPN_W-1:0] pos_x;
    logic [SPN_W-1:0] pos_p1;
    logic [20:0]      port_sum;
    res_kind_t        kind;
    logic             emit;

    function automatic logic [SPN_W-1:0] span(input logic [SPN_W-1:0] from,
                                              input logic [SPN_W-1:0] to);
        return (to >= from) ? (to - from) : '0;
    endfunction

    assign take = item_valid && out_ready;
    assign c    = item.char_byte;
    assign last = item.last_byte;
    assign ws   = (c == CH_SP) || (c == CH_TAB);
    assign alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign pos_x  = {1'b0, pos_reg};
    assign pos_p1 = pos_x + SPN_W'(1);
    // port * 10 + digit
    assign port_sum = ({5'd0, port_reg} << 3) + ({5'd0, port_reg} << 1)
                      + {13'd0, c - CH_ZERO};

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        tok_next   = tok_reg;
        hs_next    = hs_reg;
        hl_next    = hl_reg;
        port_next  = port_reg;
        ts_next    = ts_reg;
        tl_next    = tl_reg;
        err_next   = err_reg;
        kind       = RES_NONE;
        emit       = 1'b0;
        res_word   = '0;

        if (!err_reg)
        begin
            // start of an entry: skip leading whitespace, clear the record
            if (phase_reg != PH_HOST && phase_reg != PH_V6 && phase_reg != PH_SEP
                && phase_reg != PH_PORT && phase_reg != PH_TRSP && !ws)
            begin
                tok_next   = pos_x;
                phase_next = PH_HOST;
                hs_next    = '0;
                hl_next    = '0;
                port_next  = '0;
                ts_next    = '0;
                tl_next    = '0;
            end

            case (phase_next)
                PH_HOST:
                begin
                    if (c == CH_LBRACK)
                    begin
                        phase_next = PH_V6;
                        tok_next   = pos_p1;
                    end
                    else if (c == CH_COLON)
                    begin
                        phase_next = PH_PORT;
                        hs_next    = tok_next;
                        hl_next    = span(tok_next, pos_x);
                    end
                    else if (c == CH_SLASH)
                    begin
                        phase_next = PH_TRSP;
                        hs_next    = tok_next;
                        hl_next    = span(tok_next, pos_x);
                        tok_next   = pos_p1;
                    end
                    else if (c == CH_COMMA)
                    begin
                        phase_next = PH_BEG;
                        hs_next    = tok_next;
                        hl_next    = span(tok_next, pos_x);
                        kind       = RES_REC;
                    end
                    else if (ws)
                    begin
                        phase_next = PH_SEP;
                        hs_next    = tok_next;
                        hl_next    = span(tok_next, pos_x);
                    end
                end
                PH_V6:
                begin
                    if (c == CH_RBRACK)
                    begin
                        phase_next = PH_SEP;
                        hs_next    = tok_next;
                        hl_next    = span(tok_next, pos_x);
                    end
                end
                PH_SEP:
                begin
                    if (c == CH_COLON)
                    begin
                        phase_next = PH_PORT;
                    end
                    else if (c == CH_COMMA)
                    begin
                        phase_next = PH_BEG;
                        kind       = RES_REC;
                    end
                    else if (c == CH_SLASH)
                    begin
                        phase_next = PH_TRSP;
                        tok_next   = pos_p1;
                    end
                    else
                    begin
                        kind = RES_ERR;
                    end
                end
                PH_PORT:
                begin
                    if (c == CH_SLASH)
                    begin
                        phase_next = PH_TRSP;
                        tok_next   = pos_p1;
                    end
                    else if (c == CH_COMMA)
                    begin
                        phase_next = PH_BEG;
                        kind       = RES_REC;
                    end
                    else if (ws)
                    begin
                        kind = RES_NONE;
                    end
                    else if (c < CH_ZERO || c > CH_NINE)
                    begin
                        kind = RES_ERR;
                    end
                    else if (port_sum > {5'd0, PORT_MAX})
                    begin
                        port_next = PORT_MAX;
                    end
                    else
                    begin
                        port_next = port_sum[15:0];
                    end
                end
                PH_TRSP:
                begin
                    if (c == CH_COMMA)
                    begin
                        phase_next = PH_BEG;
                        ts_next    = tok_next;
                        tl_next    = span(tok_next, pos_x);
                        kind       = RES_REC;
                    end
                    else if (!alpha)
                    begin
                        kind = RES_ERR;
                    end
                end
                default:
                begin
                    kind = RES_NONE; // whitespace before an entry
                end
            endcase

            // last byte closes an open entry
            if (kind == RES_NONE && last && phase_next != PH_BEG)
            begin
                if (phase_next == PH_HOST)
                begin
                    hs_next = tok_next;
                    hl_next = span(tok_next, pos_p1);
                end
                else if (phase_next == PH_TRSP)
                begin
                    ts_next = tok_next;
                    tl_next = span(tok_next, pos_p1);
                end
                kind = RES_REC;
            end

            if (kind == RES_ERR)
            begin
                emit            = 1'b1;
                err_next        = 1'b1;
                res_word.status = 1'b1;
            end
            else if (kind == RES_REC)
            begin
                emit                      = 1'b1;
                res_word.host_start       = (hl_next != '0) ? 10'(hs_next) : 10'd0;
                res_word.host_length      = 11'(hl_next);
                res_word.port_number      = port_next;
                res_word.transport_start  = (tl_next != '0) ? 10'(ts_next) : 10'd0;
                res_word.transport_length = 11'(tl_next);
            end
            res_word.end_of_list = last;
        end

        if (last)
        begin
            phase_next = PH_BEG;
            pos_next   = '0;
            tok_next   = '0;
            hs_next    = '0;
            hl_next    = '0;
            port_next  = '0;
            ts_next    = '0;
            tl_next    = '0;
            err_next   = 1'b0;
        end
        else if (pos_reg < POS_LAST)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    assign res_valid = take && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BEG;
            pos_reg   <= '0;
            tok_reg   <= '0;
            hs_reg    <= '0;
            hl_reg    <= '0;
            port_reg  <= '0;
            ts_reg    <= '0;
            tl_reg    <= '0;
            err_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tok_reg   <= tok_next;
            hs_reg    <= hs_next;
            hl_reg    <= hl_next;
            port_reg  <= port_next;
            ts_reg    <= ts_next;
            tl_reg    <= tl_next;
            err_reg   <= err_next;
        end
    end

endmodule

### design/nhl_out_stage.sv
// Result register of the next-hop list parser: holds a record word while
// the receiver stalls. Depends on nhl_pkg.
module nhl_out_stage
    import nhl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    input  out_word_t res_word,
    output logic      out_ready,
    output logic      rec_valid,
    input  logic      rec_stall,
    output out_word_t rec_word
);

    logic      vld_reg;
    out_word_t word_reg;

    assign out_ready = !vld_reg || !rec_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            vld_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && res_valid)
        begin
            word_reg <= res_word;
        end
    end

    assign rec_valid = vld_reg;
    assign rec_word  = word_reg;

endmodule
